[src/pmm_pkg.sv]
// Shared types and constants for the paged memory manager.
`default_nettype none
package pmm_pkg;

   localparam int ADDR_BITS      = 20;
   localparam int SIZE_BITS      = 21;
   localparam int KIND_BITS      = 2;
   localparam int SLOT_IN_BITS   = 2;
   localparam int BYTE_BITS      = 8;
   localparam int REL_BITS       = 11;
   localparam int REQ_TDATA_BITS = 56;
   localparam int RSP_TDATA_BITS = 40;

   localparam int OFFSET_BITS_DEF = 10;
   localparam int FRAME_COUNT_DEF = 1024;
   localparam int PROC_COUNT_DEF  = 4;

   typedef enum logic [1:0] {
      KIND_ALLOC,
      KIND_FREE,
      KIND_READ,
      KIND_WRITE
   } kind_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ACHK,
      S_ASCAN,
      S_ATAIL,
      S_LOOK,
      S_RDATA,
      S_FWALK,
      S_FDONE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic clr;
      logic we;
      logic re;
   } mem_ctrl_type;

endpackage
`default_nettype wire

[src/pmm_sram.sv]
// Single-port-write, registered-read memory with a clear sweep input.
`default_nettype none
module pmm_sram #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = 4,
   parameter int CLR_BITS  = 4
) (
   input  wire                       clock,
   input  pmm_pkg::mem_ctrl_type     ctrl,
   input  wire logic [CLR_BITS-1:0]  clr_addr,
   input  wire logic [ADDR_BITS-1:0] waddr,
   input  wire logic [DATA_BITS-1:0] wdata,
   input  wire logic [ADDR_BITS-1:0] raddr,
   output logic      [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rdata_ff;
   logic                 clr_hit;

   assign clr_hit = ctrl.clr && ({1'b0, clr_addr} < (CLR_BITS+1)'(DEPTH));

   always_ff @(posedge clock) begin
      if (clr_hit) begin
         mem_ff[clr_addr[ADDR_BITS-1:0]] <= '0;
      end else if (ctrl.we) begin
         mem_ff[waddr] <= wdata;
      end
      if (ctrl.re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[src/paged_memory_manager_unit.sv]
// Paged memory manager top level: request sequencer, page map, frame table, byte store.
//
//   channel | dir | handshake              | payload
//   req     | in  | req_tvalid/req_tready  | tuser kind, tdata slot/size/address/wdata
//   rsp     | out | rsp_tvalid/rsp_tready  | tuser status, tdata start/rdata/released
//
// After reset a clearing pass zeroes every map, frame table and byte store entry;
// no request is taken during it.
// Allocate scans the frame table one entry per cycle, skipping the scan on failure
// or zero size; free walks the frame chain.
// The single frame table read port sets the allocate and free rates.
// A finished result waits in the rsp register; the next request is taken meanwhile.
`default_nettype none
module paged_memory_manager_unit #(
   parameter int OFFSET_BITS = pmm_pkg::OFFSET_BITS_DEF,
   parameter int FRAME_COUNT = pmm_pkg::FRAME_COUNT_DEF,
   parameter int PROC_COUNT  = pmm_pkg::PROC_COUNT_DEF
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    req_tvalid,
   output logic                                   req_tready,
   input  wire logic [pmm_pkg::KIND_BITS-1:0]      req_tuser,  // kind
   // proc_slot[1:0], request_size[22:2], address[42:23], write_data[50:43]
   input  wire logic [pmm_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire                                    rsp_tready,
   output logic                                   rsp_tuser,  // status
   // region_start[19:0], read_data[27:20], pages_released[38:28]
   output logic      [pmm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);

   localparam int VP_BITS        = pmm_pkg::ADDR_BITS - OFFSET_BITS;
   localparam int VPAGES         = 1 << VP_BITS;
   localparam int PAGE_BYTES     = 1 << OFFSET_BITS;
   localparam int SLOT_BITS      = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
   localparam int FRAME_BITS     = $clog2(FRAME_COUNT);
   localparam int FCNT_BITS      = $clog2(FRAME_COUNT + 1);
   localparam int OWNER_BITS     = $clog2(PROC_COUNT + 1);
   localparam int FE_BITS        = OWNER_BITS + FRAME_BITS + 1;
   localparam int MAP_BITS       = 1 + FRAME_BITS;
   localparam int MAP_ADDR_BITS  = SLOT_BITS + VP_BITS;
   localparam int MAP_DEPTH      = 1 << MAP_ADDR_BITS;
   localparam int BYTE_ADDR_BITS = FRAME_BITS + OFFSET_BITS;
   localparam int BYTE_DEPTH     = FRAME_COUNT << OFFSET_BITS;
   localparam int VLIMIT         = (FRAME_COUNT < VPAGES) ? FRAME_COUNT : VPAGES;
   localparam int BRK_BITS       = VP_BITS + 1;
   localparam int NEED_BITS      = pmm_pkg::SIZE_BITS - OFFSET_BITS + 1;
   localparam int MX1            = (NEED_BITS > BRK_BITS) ? NEED_BITS : BRK_BITS;
   localparam int CW             = ((MX1 > FCNT_BITS) ? MX1 : FCNT_BITS) + 1;
   localparam int CLR_D1         = (MAP_DEPTH > FRAME_COUNT) ? MAP_DEPTH : FRAME_COUNT;
   localparam int CLR_DEPTH      = (CLR_D1 > BYTE_DEPTH) ? CLR_D1 : BYTE_DEPTH;
   localparam int CLR_BITS       = $clog2(CLR_DEPTH);

   // request fields
   logic [1:0]                     req_slot;
   logic [pmm_pkg::SIZE_BITS-1:0]  req_size;
   logic [pmm_pkg::ADDR_BITS-1:0]  req_addr;
   logic [pmm_pkg::BYTE_BITS-1:0]  req_wdata;

   assign req_slot  = req_tdata[1:0];
   assign req_size  = req_tdata[22:2];
   assign req_addr  = req_tdata[42:23];
   assign req_wdata = req_tdata[50:43];

   // control registers
   pmm_pkg::state_type state_ff, state_in;
   logic [CLR_BITS-1:0]  clr_ff, clr_in;
   logic [BRK_BITS-1:0]  brk_ff [PROC_COUNT];
   logic [BRK_BITS-1:0]  brk_in [PROC_COUNT];
   logic [FCNT_BITS-1:0] free_cnt_ff, free_cnt_in;
   logic                 rdv_ff, rdv_in;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;

   // working registers
   logic [1:0]                    slot_ff, slot_in;
   pmm_pkg::kind_type             kind_ff, kind_in;
   logic [pmm_pkg::ADDR_BITS-1:0] addr_ff, addr_in;
   logic [pmm_pkg::BYTE_BITS-1:0] wdata_ff, wdata_in;
   logic [NEED_BITS-1:0]          need_ff, need_in;
   logic [FCNT_BITS-1:0]          scan_ff, scan_in;
   logic [FRAME_BITS-1:0]         rda_ff, rda_in;
   logic [NEED_BITS-1:0]          i_ff, i_in;
   logic [FRAME_BITS-1:0]         prev_ff, prev_in;
   logic [VP_BITS-1:0]            mvp_ff, mvp_in;
   logic [FRAME_BITS-1:0]         f_ff, f_in;
   logic [FCNT_BITS-1:0]          n_ff, n_in;
   logic [VP_BITS:0]              vp_ff, vp_in;
   logic                          status_ff, status_in;
   logic [pmm_pkg::ADDR_BITS-1:0] start_ff, start_in;
   logic [pmm_pkg::BYTE_BITS-1:0] rdd_ff, rdd_in;
   logic                          rsp_tuser_ff;
   logic [pmm_pkg::RSP_TDATA_BITS-1:0] rsp_tdata_ff;

   // memory ports
   pmm_pkg::mem_ctrl_type     m_ctrl, f_ctrl, b_ctrl;
   logic [MAP_ADDR_BITS-1:0]  m_waddr, m_raddr;
   logic [MAP_BITS-1:0]       m_wdata, m_rdata;
   logic [FRAME_BITS-1:0]     f_waddr, f_raddr;
   logic [FE_BITS-1:0]        f_wdata, f_rdata;
   logic [BYTE_ADDR_BITS-1:0] phys;
   logic [pmm_pkg::BYTE_BITS-1:0] b_rdata;

   // decoded helpers
   logic [SLOT_BITS-1:0]  slot_idx;
   logic                  slot_ok;
   logic [BRK_BITS-1:0]   brk_cur;
   logic [CW-1:0]         room;
   logic                  alloc_ok;
   logic [OWNER_BITS-1:0] owner_val;
   logic [OWNER_BITS-1:0] fe_owner;
   logic [FRAME_BITS-1:0] fe_next;
   logic                  fe_last;
   logic                  map_valid;
   logic [FRAME_BITS-1:0] map_frame;
   logic                  found;
   logic [NEED_BITS-1:0]  i_next;
   logic                  last_find;
   logic                  walk_stop;
   logic                  walk_end;
   logic [VP_BITS-1:0]    vp_base;
   logic                  brk_hit;
   logic                  rsp_load;

   assign slot_idx  = SLOT_BITS'(slot_ff);
   assign slot_ok   = int'(req_slot) < PROC_COUNT;
   assign brk_cur   = brk_ff[slot_idx];
   assign room      = (CW'(brk_cur) <= CW'(VLIMIT)) ? (CW'(VLIMIT) - CW'(brk_cur)) : '0;
   assign alloc_ok  = (CW'(need_ff) <= room) && (CW'(need_ff) <= CW'(free_cnt_ff));
   assign owner_val = OWNER_BITS'({1'b0, slot_ff} + 3'd1);
   assign fe_owner  = f_rdata[FE_BITS-1 -: OWNER_BITS];
   assign fe_next   = f_rdata[FRAME_BITS:1];
   assign fe_last   = f_rdata[0];
   assign map_valid = m_rdata[FRAME_BITS];
   assign map_frame = m_rdata[FRAME_BITS-1:0];
   assign found     = rdv_ff && (fe_owner == '0);
   assign i_next    = i_ff + NEED_BITS'(1);
   assign last_find = (i_next == need_ff);
   assign walk_stop = fe_last || (fe_owner == '0);
   assign walk_end  = (n_ff + FCNT_BITS'(1)) == FCNT_BITS'(FRAME_COUNT);
   assign vp_base   = VP_BITS'(addr_ff >> OFFSET_BITS);
   assign brk_hit   = (addr_ff[OFFSET_BITS-1:0] == '0)
                      && ((CW'(vp_base) + CW'(n_ff)) == CW'(brk_cur));
   assign phys      = {map_frame, addr_ff[OFFSET_BITS-1:0]};
   assign rsp_load  = (state_ff == pmm_pkg::S_RESP) && (!rsp_tvalid_ff || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pmm_pkg::S_CLEAR: begin
            if (clr_ff == CLR_BITS'(CLR_DEPTH - 1)) state_in = pmm_pkg::S_IDLE;
         end
         pmm_pkg::S_IDLE: begin
            if (req_tvalid) begin
               if (!slot_ok) begin
                  state_in = pmm_pkg::S_RESP;
               end else if (pmm_pkg::kind_type'(req_tuser) == pmm_pkg::KIND_ALLOC) begin
                  state_in = pmm_pkg::S_ACHK;
               end else begin
                  state_in = pmm_pkg::S_LOOK;
               end
            end
         end
         pmm_pkg::S_ACHK: begin
            if (!alloc_ok || (need_ff == '0)) state_in = pmm_pkg::S_RESP;
            else state_in = pmm_pkg::S_ASCAN;
         end
         pmm_pkg::S_ASCAN: begin
            if (found && last_find) state_in = pmm_pkg::S_ATAIL;
         end
         pmm_pkg::S_ATAIL: state_in = pmm_pkg::S_RESP;
         pmm_pkg::S_LOOK: begin
            if (!map_valid) begin
               state_in = (kind_ff == pmm_pkg::KIND_FREE) ? pmm_pkg::S_FDONE
                                                          : pmm_pkg::S_RESP;
            end else begin
               unique case (kind_ff)
                  pmm_pkg::KIND_FREE: state_in = pmm_pkg::S_FWALK;
                  pmm_pkg::KIND_READ: state_in = pmm_pkg::S_RDATA;
                  default:            state_in = pmm_pkg::S_RESP;
               endcase
            end
         end
         pmm_pkg::S_RDATA: state_in = pmm_pkg::S_RESP;
         pmm_pkg::S_FWALK: begin
            if (walk_stop || walk_end) state_in = pmm_pkg::S_FDONE;
         end
         pmm_pkg::S_FDONE: state_in = pmm_pkg::S_RESP;
         pmm_pkg::S_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = pmm_pkg::S_IDLE;
         end
         default: state_in = pmm_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      req_tready  = 1'b0;
      clr_in      = clr_ff;
      brk_in      = brk_ff;
      free_cnt_in = free_cnt_ff;
      rdv_in      = 1'b0;
      slot_in     = slot_ff;
      kind_in     = kind_ff;
      addr_in     = addr_ff;
      wdata_in    = wdata_ff;
      need_in     = need_ff;
      scan_in     = scan_ff;
      rda_in      = rda_ff;
      i_in        = i_ff;
      prev_in     = prev_ff;
      mvp_in      = mvp_ff;
      f_in        = f_ff;
      n_in        = n_ff;
      vp_in       = vp_ff;
      status_in   = status_ff;
      start_in    = start_ff;
      rdd_in      = rdd_ff;
      m_ctrl      = '0;
      f_ctrl      = '0;
      b_ctrl      = '0;
      m_waddr     = '0;
      m_wdata     = '0;
      m_raddr     = '0;
      f_waddr     = '0;
      f_wdata     = '0;
      f_raddr     = '0;
      unique case (state_ff)
         pmm_pkg::S_CLEAR: begin
            m_ctrl.clr = 1'b1;
            f_ctrl.clr = 1'b1;
            b_ctrl.clr = 1'b1;
            clr_in     = clr_ff + CLR_BITS'(1);
         end
         pmm_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               slot_in    = req_slot;
               kind_in    = pmm_pkg::kind_type'(req_tuser);
               addr_in    = req_addr;
               wdata_in   = req_wdata;
               need_in    = NEED_BITS'(({1'b0, req_size} + 22'(PAGE_BYTES - 1)) >> OFFSET_BITS);
               status_in  = 1'b1;
               start_in   = '0;
               rdd_in     = '0;
               n_in       = '0;
               m_ctrl.re  = 1'b1;
               m_raddr    = {SLOT_BITS'(req_slot), VP_BITS'(req_addr >> OFFSET_BITS)};
            end
         end
         pmm_pkg::S_ACHK: begin
            scan_in = '0;
            i_in    = '0;
            mvp_in  = brk_cur[VP_BITS-1:0];
            if (alloc_ok) begin
               status_in        = 1'b0;
               start_in         = {brk_cur[VP_BITS-1:0], {OFFSET_BITS{1'b0}}};
               brk_in[slot_idx] = BRK_BITS'(CW'(brk_cur) + CW'(need_ff));
            end
         end
         pmm_pkg::S_ASCAN: begin
            if (scan_ff < FCNT_BITS'(FRAME_COUNT)) begin
               f_ctrl.re = 1'b1;
               f_raddr   = scan_ff[FRAME_BITS-1:0];
               rdv_in    = 1'b1;
               rda_in    = scan_ff[FRAME_BITS-1:0];
               scan_in   = scan_ff + FCNT_BITS'(1);
            end
            if (found) begin
               m_ctrl.we = 1'b1;
               m_waddr   = {slot_idx, mvp_ff};
               m_wdata   = {1'b1, rda_ff};
               if (i_ff != '0) begin
                  f_ctrl.we = 1'b1;
                  f_waddr   = prev_ff;
                  f_wdata   = {owner_val, rda_ff, 1'b0};
               end
               free_cnt_in = free_cnt_ff - FCNT_BITS'(1);
               prev_in     = rda_ff;
               i_in        = i_next;
               mvp_in      = mvp_ff + VP_BITS'(1);
            end
         end
         pmm_pkg::S_ATAIL: begin
            f_ctrl.we = 1'b1;
            f_waddr   = prev_ff;
            f_wdata   = {owner_val, {FRAME_BITS{1'b0}}, 1'b1};
         end
         pmm_pkg::S_LOOK: begin
            if (map_valid) begin
               case (kind_ff)
                  pmm_pkg::KIND_FREE: begin
                     status_in = 1'b0;
                     f_ctrl.re = 1'b1;
                     f_raddr   = map_frame;
                     f_in      = map_frame;
                     vp_in     = {1'b0, vp_base};
                  end
                  pmm_pkg::KIND_READ: begin
                     status_in = 1'b0;
                     b_ctrl.re = 1'b1;
                  end
                  pmm_pkg::KIND_WRITE: begin
                     status_in = 1'b0;
                     b_ctrl.we = 1'b1;
                  end
                  default: status_in = status_ff;
               endcase
            end
         end
         pmm_pkg::S_RDATA: begin
            rdd_in = b_rdata;
         end
         pmm_pkg::S_FWALK: begin
            f_ctrl.we = 1'b1;
            f_waddr   = f_ff;
            f_wdata   = '0;
            if (fe_owner != '0) free_cnt_in = free_cnt_ff + FCNT_BITS'(1);
            if (!vp_ff[VP_BITS]) begin
               m_ctrl.we = 1'b1;
               m_waddr   = {slot_idx, vp_ff[VP_BITS-1:0]};
               m_wdata   = '0;
               vp_in     = vp_ff + (VP_BITS+1)'(1);
            end
            n_in = n_ff + FCNT_BITS'(1);
            if (!(walk_stop || walk_end)) begin
               f_ctrl.re = 1'b1;
               f_raddr   = fe_next;
               f_in      = fe_next;
            end
         end
         pmm_pkg::S_FDONE: begin
            if (brk_hit) brk_in[slot_idx] = BRK_BITS'(vp_base);
         end
         pmm_pkg::S_RESP: begin
            rdv_in = 1'b0;
         end
         default: rdv_in = 1'b0;
      endcase
   end

   assign rsp_tvalid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_tvalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pmm_pkg::S_CLEAR;
         clr_ff        <= '0;
         free_cnt_ff   <= FCNT_BITS'(FRAME_COUNT);
         rdv_ff        <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         for (int p = 0; p < PROC_COUNT; p++) begin
            brk_ff[p] <= BRK_BITS'(1);
         end
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_cnt_ff   <= free_cnt_in;
         rdv_ff        <= rdv_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         brk_ff        <= brk_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff   <= slot_in;
      kind_ff   <= kind_in;
      addr_ff   <= addr_in;
      wdata_ff  <= wdata_in;
      need_ff   <= need_in;
      scan_ff   <= scan_in;
      rda_ff    <= rda_in;
      i_ff      <= i_in;
      prev_ff   <= prev_in;
      mvp_ff    <= mvp_in;
      f_ff      <= f_in;
      n_ff      <= n_in;
      vp_ff     <= vp_in;
      status_ff <= status_in;
      start_ff  <= start_in;
      rdd_ff    <= rdd_in;
      if (rsp_load) begin
         rsp_tuser_ff <= status_ff;
         rsp_tdata_ff <= {1'b0, pmm_pkg::REL_BITS'(n_ff), rdd_ff, start_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   pmm_sram #(
      .DATA_BITS (MAP_BITS),
      .DEPTH     (MAP_DEPTH),
      .ADDR_BITS (MAP_ADDR_BITS),
      .CLR_BITS  (CLR_BITS)
   ) u_page_map (
      .clock    (clock),
      .ctrl     (m_ctrl),
      .clr_addr (clr_ff),
      .waddr    (m_waddr),
      .wdata    (m_wdata),
      .raddr    (m_raddr),
      .rdata    (m_rdata)
   );

   pmm_sram #(
      .DATA_BITS (FE_BITS),
      .DEPTH     (FRAME_COUNT),
      .ADDR_BITS (FRAME_BITS),
      .CLR_BITS  (CLR_BITS)
   ) u_frame_table (
      .clock    (clock),
      .ctrl     (f_ctrl),
      .clr_addr (clr_ff),
      .waddr    (f_waddr),
      .wdata    (f_wdata),
      .raddr    (f_raddr),
      .rdata    (f_rdata)
   );

   pmm_sram #(
      .DATA_BITS (pmm_pkg::BYTE_BITS),
      .DEPTH     (BYTE_DEPTH),
      .ADDR_BITS (BYTE_ADDR_BITS),
      .CLR_BITS  (CLR_BITS)
   ) u_byte_store (
      .clock    (clock),
      .ctrl     (b_ctrl),
      .clr_addr (clr_ff),
      .waddr    (phys),
      .wdata    (wdata_ff),
      .raddr    (phys),
      .rdata    (b_rdata)
   );

   a_free_cnt_range: assert property (@(posedge clock) disable iff (reset)
      free_cnt_ff <= FCNT_BITS'(FRAME_COUNT))
      else $error("free frame count above frame count");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   a_scan_has_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pmm_pkg::S_ASCAN && found) |-> (free_cnt_ff != '0))
      else $error("allocate found frame with no free count left");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pmm_pkg::S_FWALK) |-> (n_ff < FCNT_BITS'(FRAME_COUNT)))
      else $error("frame chain walk overran");

endmodule
`default_nettype wire
